FILE: hdl/txc_pkg.sv
// Text console writer: shared package.
// Field widths, action codes, control character codes and parameter defaults.
// No dependencies.
package txc_pkg;

   localparam int COLUMNS_DEFAULT  = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STOP_DEFAULT = 4;

   localparam int ACTION_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int ADDR_IN_W = 11;
   localparam int COL_OUT_W = 7;
   localparam int ROW_OUT_W = 5;
   localparam int POS_OUT_W = 11;

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [ATTR_W-1:0] COLOR_AT_RESET = 8'h07;

endpackage

FILE: hdl/txc_channels.sv
// Text console writer: channel interfaces (request, response, register write).
// Depends on txc_pkg for field widths.

interface txc_req_if import txc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [CHAR_W-1:0]    char_code;
   logic [ADDR_IN_W-1:0] cell_address;

   modport source (output valid, action, char_code, cell_address, input ready);
   modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

interface txc_rsp_if import txc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COL_OUT_W-1:0] cursor_column;
   logic [ROW_OUT_W-1:0] cursor_row;
   logic [POS_OUT_W-1:0] cursor_position;
   logic [CHAR_W-1:0]    cell_character;
   logic [ATTR_W-1:0]    cell_attribute;

   modport source (output valid, cursor_column, cursor_row, cursor_position,
                   cell_character, cell_attribute, input ready);
   modport sink   (input valid, cursor_column, cursor_row, cursor_position,
                   cell_character, cell_attribute, output ready);
endinterface

interface txc_csr_if import txc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/text_console_writer.sv
// Text console writer: top level, cursor sequencer and cell store.
// Depends on txc_pkg and the channel interfaces in txc_channels.sv.
//
// Channels
//   req_bus : one transfer per action (put byte, read cell, clear screen).
//   rsp_bus : one transfer per request: cursor after the action and, for a
//             read, the addressed cell (zero otherwise).
//   csr_bus : default colour write; ready only while the sequencer is idle.
// Sequencing
//   Cell store has one write and one registered read port; multi-cell work
//   sweeps one cell per cycle. A scroll copies the rows up, then blanks the
//   bottom row. One request in progress at a time.
// Reset
//   Homes the cursor, sets the colour to 7 and blanks the store before the
//   first request transfer.
// Stalls
//   A result waits in an output register; the next request is taken
//   meanwhile and its result waits until the previous one has been transferred.
module text_console_writer import txc_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEFAULT,
   parameter int ROWS     = ROWS_DEFAULT,
   parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   txc_req_if.sink   req_bus,
   txc_rsp_if.source rsp_bus,
   txc_csr_if.sink   csr_bus
);

   // ---------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------
   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int POS_W  = $clog2(CELLS + 1);   // holds CELLS itself
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int TAB_W  = $clog2(TAB_STOP + 1);

   localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [POS_W-1:0] POS_COLS    = POS_W'(COLUMNS);
   localparam logic [POS_W-1:0] POS_CELLS   = POS_W'(CELLS);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(CELLS - 1);
   localparam logic [POS_W-1:0] POS_LASTROW = POS_W'(CELLS - COLUMNS);
   localparam logic [TAB_W-1:0] TAB_FULL    = TAB_W'(TAB_STOP);
   localparam logic [TAB_W-1:0] PHASE_TOP   = TAB_W'(TAB_STOP - 1);
   localparam logic [TAB_W-1:0] PHASE_LAST  = TAB_W'((COLUMNS - 1) % TAB_STOP);

   typedef enum logic [2:0] {
      ST_CLEAR,   // blanking sweep (reset and clear-screen action)
      ST_IDLE,
      ST_READ,    // memory read data returning
      ST_PUT,     // one plain character per cycle, paused by a scroll
      ST_COPY,    // scroll: move rows up, pipelined read/write
      ST_FILL,    // scroll: blank the bottom row
      ST_DONE     // wait for the output register
   } state_type;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type          state_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   line_ff;
   logic [POS_W-1:0]   pos_ff;      // line_ff * COLUMNS + col_ff, kept incrementally
   logic [TAB_W-1:0]   phase_ff;    // col_ff mod TAB_STOP, kept incrementally
   logic [TAB_W-1:0]   left_ff;     // plain characters still to put
   logic [CHAR_W-1:0]  char_ff;
   logic [POS_W-1:0]   sweep_ff;
   logic               pend_ff;     // copy write due this cycle
   logic               clear_reply_ff;
   logic [CELL_W-1:0]  cell_ff;
   logic [ATTR_W-1:0]  color_ff;

   logic               rsp_valid_ff;
   logic [COL_OUT_W-1:0] rsp_column_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [POS_OUT_W-1:0] rsp_position_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic [ATTR_W-1:0]  rsp_attr_ff;

   // Cell store: character in the low byte, attribute in the high byte
   logic [CELL_W-1:0]  cell_mem_ff [0:CELLS-1];
   logic [CELL_W-1:0]  cell_rd_ff;

   // ---------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------
   logic req_take;
   logic rsp_take;
   logic rsp_free;
   logic in_bounds;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   // colour only changes between sweeps
   assign csr_bus.ready = (state_ff == ST_IDLE);
   assign in_bounds     = 32'(req_bus.cell_address) < 32'(CELLS);

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cursor_column   = rsp_column_ff;
   assign rsp_bus.cursor_row      = rsp_row_ff;
   assign rsp_bus.cursor_position = rsp_position_ff;
   assign rsp_bus.cell_character  = rsp_char_ff;
   assign rsp_bus.cell_attribute  = rsp_attr_ff;

   // ---------------------------------------------------------------
   // Memory port control
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] mem_ra;
   logic [ADDR_W-1:0] mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              mem_we_char;
   logic              mem_we_attr;
   logic [POS_W-1:0]  copy_dst;

   assign copy_dst = sweep_ff - POS_COLS - POS_W'(1);

   always_comb begin
      mem_ra      = sweep_ff[ADDR_W-1:0];
      mem_wa      = sweep_ff[ADDR_W-1:0];
      mem_wd      = {color_ff, CH_NUL};
      mem_we_char = 1'b0;
      mem_we_attr = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_ra = ADDR_W'(req_bus.cell_address);
            mem_wa = ADDR_W'(pos_ff - POS_W'(1));
            mem_wd = {color_ff, CH_NUL};
            // backspace clears the character it steps back onto
            if (req_take && req_bus.action == ACT_PUT &&
                req_bus.char_code == CH_BACKSPACE &&
                (col_ff != '0 || line_ff != '0)) begin
               mem_we_char = 1'b1;
            end
         end
         ST_PUT: begin
            mem_wa      = pos_ff[ADDR_W-1:0];
            mem_wd      = {color_ff, char_ff};
            mem_we_char = 1'b1;
         end
         ST_COPY: begin
            mem_wa      = copy_dst[ADDR_W-1:0];
            mem_wd      = cell_rd_ff;
            mem_we_char = pend_ff;
            mem_we_attr = pend_ff;
         end
         ST_FILL, ST_CLEAR: begin
            mem_we_char = 1'b1;
            mem_we_attr = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we_char) begin
         cell_mem_ff[mem_wa][CHAR_W-1:0] <= mem_wd[CHAR_W-1:0];
      end
      if (mem_we_attr) begin
         cell_mem_ff[mem_wa][CELL_W-1:CHAR_W] <= mem_wd[CELL_W-1:CHAR_W];
      end
      cell_rd_ff <= cell_mem_ff[mem_ra];
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         col_ff         <= '0;
         line_ff        <= '0;
         pos_ff         <= '0;
         phase_ff       <= '0;
         left_ff        <= '0;
         sweep_ff       <= '0;
         pend_ff        <= 1'b0;
         clear_reply_ff <= 1'b0;
         color_ff       <= COLOR_AT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            color_ff <= csr_bus.data;
         end
         // output register: load from the done state, else drop on transfer
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + POS_W'(1);
               if (sweep_ff == POS_LAST) begin
                  state_ff <= clear_reply_ff ? ST_DONE : ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_take) begin
                  cell_ff <= '0;
                  unique case (req_bus.action)
                     ACT_PUT: begin
                        priority case (req_bus.char_code)
                           CH_NEWLINE: begin
                              col_ff   <= '0;
                              phase_ff <= '0;
                              left_ff  <= '0;
                              pos_ff   <= pos_ff - POS_W'(col_ff) + POS_COLS;
                              if (line_ff == ROW_LAST) begin
                                 sweep_ff <= POS_COLS;
                                 pend_ff  <= 1'b0;
                                 state_ff <= ST_COPY;
                              end else begin
                                 line_ff  <= line_ff + ROW_W'(1);
                                 state_ff <= ST_DONE;
                              end
                           end
                           CH_RETURN: begin
                              col_ff   <= '0;
                              phase_ff <= '0;
                              pos_ff   <= pos_ff - POS_W'(col_ff);
                              state_ff <= ST_DONE;
                           end
                           CH_BACKSPACE: begin
                              if (col_ff != '0) begin
                                 col_ff   <= col_ff - COL_W'(1);
                                 pos_ff   <= pos_ff - POS_W'(1);
                                 phase_ff <= (phase_ff == '0) ? PHASE_TOP
                                                              : phase_ff - TAB_W'(1);
                              end else if (line_ff != '0) begin
                                 line_ff  <= line_ff - ROW_W'(1);
                                 col_ff   <= COL_LAST;
                                 pos_ff   <= pos_ff - POS_W'(1);
                                 phase_ff <= PHASE_LAST;
                              end
                              state_ff <= ST_DONE;
                           end
                           CH_TAB: begin
                              left_ff  <= TAB_FULL - phase_ff;
                              char_ff  <= CH_SPACE;
                              state_ff <= ST_PUT;
                           end
                           default: begin
                              left_ff  <= TAB_W'(1);
                              char_ff  <= req_bus.char_code;
                              state_ff <= ST_PUT;
                           end
                        endcase
                     end
                     ACT_READ: begin
                        state_ff <= in_bounds ? ST_READ : ST_DONE;
                     end
                     ACT_CLEAR: begin
                        col_ff         <= '0;
                        line_ff        <= '0;
                        pos_ff         <= '0;
                        phase_ff       <= '0;
                        sweep_ff       <= '0;
                        clear_reply_ff <= 1'b1;
                        state_ff       <= ST_CLEAR;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end

            ST_READ: begin
               cell_ff  <= cell_rd_ff;
               state_ff <= ST_DONE;
            end

            ST_PUT: begin
               left_ff <= left_ff - TAB_W'(1);
               pos_ff  <= pos_ff + POS_W'(1);
               if (col_ff == COL_LAST) begin
                  col_ff   <= '0;
                  phase_ff <= '0;
                  if (line_ff == ROW_LAST) begin
                     sweep_ff <= POS_COLS;
                     pend_ff  <= 1'b0;
                     state_ff <= ST_COPY;
                  end else begin
                     line_ff  <= line_ff + ROW_W'(1);
                     state_ff <= (left_ff == TAB_W'(1)) ? ST_DONE : ST_PUT;
                  end
               end else begin
                  col_ff   <= col_ff + COL_W'(1);
                  phase_ff <= (phase_ff == PHASE_TOP) ? '0 : phase_ff + TAB_W'(1);
                  state_ff <= (left_ff == TAB_W'(1)) ? ST_DONE : ST_PUT;
               end
            end

            ST_COPY: begin
               pend_ff <= (sweep_ff != POS_CELLS);
               if (sweep_ff == POS_CELLS) begin
                  sweep_ff <= POS_LASTROW;
                  state_ff <= ST_FILL;
               end else begin
                  sweep_ff <= sweep_ff + POS_W'(1);
               end
            end

            ST_FILL: begin
               sweep_ff <= sweep_ff + POS_W'(1);
               if (sweep_ff == POS_LAST) begin
                  // cursor stays on the bottom row after the scroll
                  pos_ff   <= pos_ff - POS_COLS;
                  state_ff <= (left_ff == '0) ? ST_DONE : ST_PUT;
               end
            end

            ST_DONE: begin
               if (rsp_free) begin
                  rsp_column_ff   <= COL_OUT_W'(col_ff);
                  rsp_row_ff      <= ROW_OUT_W'(line_ff);
                  rsp_position_ff <= POS_OUT_W'(pos_ff);
                  rsp_char_ff     <= cell_ff[CHAR_W-1:0];
                  rsp_attr_ff     <= cell_ff[CELL_W-1:CHAR_W];
                  state_ff        <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_LAST && line_ff <= ROW_LAST)
      else $error("cursor outside the screen");

   a_pos_tracks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         32'(pos_ff) == 32'(line_ff) * COLUMNS + 32'(col_ff))
      else $error("linear cursor index out of step with row and column");

   a_put_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> left_ff != '0)
      else $error("put state entered with nothing left to write");

   a_copy_dst: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY && pend_ff |-> sweep_ff > POS_COLS)
      else $error("scroll copy write below row zero");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request transfer did not start the sequencer");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: a directed stimulus table, then
// random phases under several default colours, with random idling on both channels.
// Depends on txc_pkg, the channel interfaces in txc_channels.sv and the block's RTL.
module tb;
   import txc_pkg::*;

   localparam int COLUMNS  = COLUMNS_DEFAULT;
   localparam int ROWS     = ROWS_DEFAULT;
   localparam int TAB_STOP = TAB_STOP_DEFAULT;
   localparam int CELLS    = COLUMNS * ROWS;

   localparam int RESET_CYCLES     = 12;
   localparam int PHASES           = 5;
   localparam int LF_RUN           = 20;   // newlines that open a phase, to move toward the bottom
   localparam int RANDOM_PER_PHASE = 22;
   localparam int HOLDOFF_CYCLES   = 600;
   localparam int DRAIN_CYCLES     = 40;   // idle wait before the final verdict
   localparam int CYCLE_LIMIT      = 5_000_000;

   // Action code the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [COL_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] position;
      logic [CHAR_W-1:0]    character;
      logic [ATTR_W-1:0]    attribute;
   } cursor_report_type;

   typedef struct {
      logic [ACTION_W-1:0]  action;
      logic [CHAR_W-1:0]    char_code;
      logic [ADDR_IN_W-1:0] cell_address;
      int unsigned          repeats;
      bit                   typed;    // report below is the expected one
      cursor_report_type    report;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   txc_req_if req_bus ();
   txc_rsp_if rsp_bus ();
   txc_csr_if csr_bus ();

   text_console_writer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Console predictor: own copy of the screen, cursor and default colour
   // ---------------------------------------------------------------------
   logic [CELL_W-1:0] screen [CELLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [ATTR_W-1:0] blank_attr;

   cursor_report_type report_q [$];  // expected reports, oldest first
   stim_row_type      directed_tbl [$];
   int unsigned       mismatches = 0;
   bit                calm = 1'b0;            // no idling on either side
   bit                holdoff_armed = 1'b0;   // receiver to stall for a long stretch

   function automatic void model_clear();
      for (int i = 0; i < CELLS; i++) screen[i] = {blank_attr, CH_NUL};
      cur_col = 0;
      cur_row = 0;
   endfunction

   // Whole screen moves up a line; fresh bottom line in the current colour
   function automatic void model_scroll();
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {blank_attr, CH_NUL};
      if (cur_row > 0) cur_row--;
   endfunction

   function automatic void model_settle();
      if (cur_col >= COLUMNS) begin
         cur_row++;
         cur_col = 0;
      end
      if (cur_row >= ROWS) model_scroll();
   endfunction

   // Character byte only; the cell keeps its attribute
   function automatic void model_plain(logic [CHAR_W-1:0] ch);
      screen[cur_row * COLUMNS + cur_col][CHAR_W-1:0] = ch;
      cur_col++;
      model_settle();
   endfunction

   function automatic void model_put(logic [CHAR_W-1:0] ch);
      int unsigned pad;
      case (ch)
         CH_NEWLINE: begin
            cur_col = 0;
            cur_row++;
            model_settle();
         end
         CH_RETURN: cur_col = 0;
         CH_BACKSPACE: begin
            // top-left corner: nothing moves and nothing is cleared
            if (cur_col > 0 || cur_row > 0) begin
               if (cur_col > 0) begin
                  cur_col--;
               end else begin
                  cur_row--;
                  cur_col = COLUMNS - 1;
               end
               screen[cur_row * COLUMNS + cur_col][CHAR_W-1:0] = CH_NUL;
            end
         end
         CH_TAB: begin
            // pad count fixed before the first space, so it may wrap or scroll
            pad = TAB_STOP - (cur_col % TAB_STOP);
            repeat (pad) model_plain(CH_SPACE);
         end
         default: model_plain(ch);
      endcase
   endfunction

   function automatic cursor_report_type model_step(logic [ACTION_W-1:0]  action,
                                                    logic [CHAR_W-1:0]    ch,
                                                    logic [ADDR_IN_W-1:0] addr);
      cursor_report_type rep;
      rep = '0;
      case (action)
         ACT_PUT: model_put(ch);
         ACT_READ: begin
            // beyond the store reads as zero
            if (addr < CELLS) begin
               rep.character = screen[addr][CHAR_W-1:0];
               rep.attribute = screen[addr][CELL_W-1:CHAR_W];
            end
         end
         ACT_CLEAR: model_clear();
         default: ;
      endcase
      rep.column   = COL_OUT_W'(cur_col);
      rep.row      = ROW_OUT_W'(cur_row);
      rep.position = POS_OUT_W'(cur_row * COLUMNS + cur_col);
      return rep;
   endfunction

   // Report typed into the table, read straight off the behaviour
   function automatic cursor_report_type cursor_at(int unsigned col, int unsigned row,
                                                   logic [CHAR_W-1:0] chr,
                                                   logic [ATTR_W-1:0] attr);
      cursor_report_type rep;
      rep.column    = COL_OUT_W'(col);
      rep.row       = ROW_OUT_W'(row);
      rep.position  = POS_OUT_W'(row * COLUMNS + col);
      rep.character = chr;
      rep.attribute = attr;
      return rep;
   endfunction

   function automatic void add_row(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] ch,
                                   logic [ADDR_IN_W-1:0] addr, int unsigned repeats,
                                   bit typed, cursor_report_type rep);
      stim_row_type r;
      r.action       = action;
      r.char_code    = ch;
      r.cell_address = addr;
      r.repeats      = repeats;
      r.typed        = typed;
      r.report       = rep;
      directed_tbl.push_back(r);
   endfunction

   // Mostly back-to-back, sometimes a few cycles, now and then a long gap
   function automatic int unsigned idle_gap();
      int unsigned pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic void report_failure(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got)
         report_failure($sformatf("%s expected %0d got %0d", name, want, got));
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Called at a rising edge; returns at the edge of the transfer,
   // with valid still high so a following item can go out without a gap.
   // ---------------------------------------------------------------------
   task automatic send_item(logic [ACTION_W-1:0]  action,
                            logic [CHAR_W-1:0]    ch,
                            logic [ADDR_IN_W-1:0] addr,
                            bit                   typed,
                            cursor_report_type    typed_rep);
      int unsigned       gap;
      cursor_report_type rep;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= action;
      req_bus.char_code    <= ch;
      req_bus.cell_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      // transfer done: predictor moves on in the same order as the block
      rep = model_step(action, ch, addr);
      report_q.push_back(typed ? typed_rep : rep);
   endtask

   // Register write; block is idle whenever this is called
   task automatic write_colour(logic [ATTR_W-1:0] colour);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= colour;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      blank_attr = colour;
   endtask

   task automatic wait_drained();
      while (report_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [ACTION_W-1:0]  action;
      logic [CHAR_W-1:0]    ch;
      logic [ADDR_IN_W-1:0] addr;
      logic [ATTR_W-1:0]    colour;
      int unsigned          pick;
      int unsigned          pos;
      int unsigned          back;

      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_PUT;
      req_bus.char_code    = CH_NUL;
      req_bus.cell_address = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      blank_attr = COLOR_AT_RESET;
      model_clear();

      // Directed table, reset colour still in force.
      // Reads after reset, at the store's end and beyond it, and the unused code
      add_row(ACT_READ,   CH_NUL, 11'd0,    1, 1, cursor_at(0, 0, CH_NUL, COLOR_AT_RESET));
      add_row(ACT_READ,   CH_NUL, 11'd1999, 1, 1, cursor_at(0, 0, CH_NUL, COLOR_AT_RESET));
      add_row(ACT_READ,   CH_NUL, 11'd2000, 1, 1, cursor_at(0, 0, CH_NUL, 8'h00));
      add_row(ACT_READ,   8'hFF,  11'h7FF,  1, 1, cursor_at(0, 0, CH_NUL, 8'h00));
      add_row(ACT_UNUSED, 8'hFF,  11'h7FF,  1, 1, cursor_at(0, 0, CH_NUL, 8'h00));
      // Backspace in the top-left corner does nothing
      add_row(ACT_PUT, CH_BACKSPACE, 11'd0, 1, 1, cursor_at(0, 0, CH_NUL, 8'h00));
      // Ordinary bytes, NUL among them, then tab from an odd column and from a stop
      add_row(ACT_PUT, 8'h41,  11'h7FF, 1, 1, cursor_at(1, 0, CH_NUL, 8'h00));
      add_row(ACT_PUT, 8'hFF,  11'd0,   1, 1, cursor_at(2, 0, CH_NUL, 8'h00));
      add_row(ACT_PUT, CH_NUL, 11'd0,   1, 1, cursor_at(3, 0, CH_NUL, 8'h00));
      add_row(ACT_PUT, CH_TAB, 11'd0,   1, 1, cursor_at(4, 0, CH_NUL, 8'h00));
      add_row(ACT_PUT, CH_TAB, 11'd0,   1, 1, cursor_at(8, 0, CH_NUL, 8'h00));
      add_row(ACT_READ, CH_NUL, 11'd1,  1, 1, cursor_at(8, 0, 8'hFF, COLOR_AT_RESET));
      add_row(ACT_PUT, CH_RETURN,  11'd0, 1, 1, cursor_at(0, 1 - 1, CH_NUL, 8'h00));
      add_row(ACT_PUT, CH_NEWLINE, 11'd0, 1, 1, cursor_at(0, 1, CH_NUL, 8'h00));
      // Backspace across a row boundary, wrap past the last column
      add_row(ACT_PUT, CH_BACKSPACE, 11'd0, 1, 1, cursor_at(79, 0, CH_NUL, 8'h00));
      add_row(ACT_PUT, 8'h7A, 11'd0,        1, 1, cursor_at(0, 1, CH_NUL, 8'h00));
      add_row(ACT_READ, CH_NUL, 11'd79,     1, 1, cursor_at(0, 1, 8'h7A, COLOR_AT_RESET));
      add_row(ACT_PUT, CH_BACKSPACE, 11'd0, 1, 1, cursor_at(79, 0, CH_NUL, 8'h00));
      add_row(ACT_READ, CH_NUL, 11'd79,     1, 1, cursor_at(79, 0, CH_NUL, COLOR_AT_RESET));
      // Down to the bottom row, then scroll by wrap, by newline and inside a tab
      add_row(ACT_PUT, CH_NEWLINE, 11'd0, 24, 0, '0);
      add_row(ACT_PUT, CH_TAB,     11'd0, 19, 0, '0);
      add_row(ACT_PUT, 8'h51,      11'd0,  4, 0, '0);
      add_row(ACT_READ, CH_NUL,  11'd1916, 1, 0, '0);
      add_row(ACT_PUT, CH_NEWLINE, 11'd0,  1, 0, '0);
      add_row(ACT_PUT, CH_TAB,     11'd0, 19, 0, '0);
      add_row(ACT_PUT, 8'h78,      11'd0,  2, 0, '0);
      add_row(ACT_PUT, CH_TAB,     11'd0,  1, 0, '0);
      add_row(ACT_READ, CH_NUL,  11'd1918, 1, 0, '0);
      add_row(ACT_CLEAR, 8'hFF, 11'h7FF,   1, 1, cursor_at(0, 0, CH_NUL, 8'h00));
      add_row(ACT_READ, CH_NUL, 11'd1000,  1, 1, cursor_at(0, 0, CH_NUL, COLOR_AT_RESET));

      foreach (directed_tbl[i])
         repeat (directed_tbl[i].repeats)
            send_item(directed_tbl[i].action, directed_tbl[i].char_code,
                      directed_tbl[i].cell_address, directed_tbl[i].typed,
                      directed_tbl[i].report);
      req_bus.valid <= 1'b0;
      wait_drained();

      // Random phases; the colour changes only once everything has come back
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       colour = 8'h00;
            1:       colour = 8'hFF;
            4:       colour = COLOR_AT_RESET ^ 8'h87;
            default: colour = ATTR_W'($urandom());
         endcase
         write_colour(colour);
         calm = (phase == 2);
         // one long response stall, early in the second phase
         if (phase == 1) holdoff_armed = 1'b1;

         // cursor down toward the bottom row before the random part
         repeat (LF_RUN)
            send_item(ACT_PUT, CH_NEWLINE, ADDR_IN_W'($urandom()), 1'b0, '0);

         repeat (RANDOM_PER_PHASE) begin
            pick   = $urandom_range(0, 99);
            action = ACT_PUT;
            ch     = CHAR_W'($urandom());
            addr   = ADDR_IN_W'($urandom());
            if (pick < 45) begin
               // mostly printable text, some raw bytes that may hit a control code
               if ($urandom_range(0, 3) != 0) ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
            end else if (pick < 60) begin
               ch = CH_NEWLINE;
            end else if (pick < 64) begin
               ch = CH_RETURN;
            end else if (pick < 70) begin
               ch = CH_BACKSPACE;
            end else if (pick < 77) begin
               ch = CH_TAB;
            end else if (pick < 95) begin
               action = ACT_READ;
               pos    = cur_row * COLUMNS + cur_col;
               back   = $urandom_range(0, 160);
               pick   = $urandom_range(0, 9);
               // recently written cells, anywhere, or beyond the store
               if (pick < 6)      addr = ADDR_IN_W'((pos >= back) ? pos - back : 0);
               else if (pick < 9) addr = ADDR_IN_W'($urandom_range(0, CELLS - 1));
               else               addr = ADDR_IN_W'($urandom_range(CELLS, 2**ADDR_IN_W - 1));
            end else if (pick < 97) begin
               action = ACT_CLEAR;
            end else begin
               action = ACT_UNUSED;
            end
            send_item(action, ch, addr, 1'b0, '0);
         end
         req_bus.valid <= 1'b0;
         wait_drained();
      end
      calm = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && report_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random ready, with one long hold-off that fills the block
   // ---------------------------------------------------------------------
   initial begin : response_pacing
      int unsigned stretch;
      int unsigned gap;
      rsp_bus.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_armed) begin
            rsp_bus.ready <= 1'b0;
            stretch = 0;
            while (stretch < HOLDOFF_CYCLES) begin
               @(posedge clock);
               stretch++;
            end
            holdoff_armed = 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = idle_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Each response transfer against the oldest expected report
   always @(posedge clock) begin : response_check
      cursor_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (report_q.size() == 0) begin
            report_failure($sformatf("unexpected transfer expected none got col %0d row %0d",
                                     rsp_bus.cursor_column, rsp_bus.cursor_row));
         end else begin
            want = report_q.pop_front();
            check_field("cursor_column",   want.column,    rsp_bus.cursor_column);
            check_field("cursor_row",      want.row,       rsp_bus.cursor_row);
            check_field("cursor_position", want.position,  rsp_bus.cursor_position);
            check_field("cell_character",  want.character, rsp_bus.cell_character);
            check_field("cell_attribute",  want.attribute, rsp_bus.cell_attribute);
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
hdl/txc_pkg.sv
hdl/txc_channels.sv
hdl/text_console_writer.sv
verif/tb.sv
